// ===== rtl/slrc_pkg.sv =====
// shared types, widths and codes of the sorted line read coalescer
package slrc_pkg;

    localparam int LINE_W = 32;
    localparam int BYTE_W = 48;
    localparam int REQ_W  = 5;
    localparam int KIND_W = 2;
    localparam int DEF_MAX_REQUESTS = 32;

    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [1:0] REG_TOTAL_LINES = 2'd0;
    localparam logic [1:0] REG_MAX_GAP     = 2'd1;
    localparam logic [1:0] REG_MAX_READ    = 2'd2;

    localparam logic [LINE_W-1:0] RST_TOTAL_LINES = 32'd0;
    localparam logic [BYTE_W-1:0] RST_MAX_GAP     = 48'd4096;
    localparam logic [BYTE_W-1:0] RST_MAX_READ    = 48'd1048576;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] last;
        logic              known;
        logic [REQ_W-1:0]  req;
    } t_ent;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } t_cell_ctl;

endpackage

// ===== rtl/slrc_cell.sv =====
// one cell of the sorted request chain: stable insert and shift toward the head
module slrc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slrc_pkg::t_cell_ctl i_ctl,
    input  slrc_pkg::t_ent     i_new,
    input  logic               i_prev_valid,
    input  slrc_pkg::t_ent     i_prev_ent,
    input  logic               i_prev_bigger,
    input  logic               i_next_valid,
    input  slrc_pkg::t_ent     i_next_ent,
    output logic               o_valid,
    output slrc_pkg::t_ent     o_ent,
    output logic               o_bigger
);

    logic           r_valid;
    slrc_pkg::t_ent r_ent;

    assign o_bigger = !r_valid || (r_ent.line > i_new.line);
    assign o_valid  = r_valid;
    assign o_ent    = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.pop) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.ins) begin
            if (i_prev_bigger) begin
                r_valid <= i_prev_valid;
            end else if (o_bigger) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_ent <= i_next_ent;
        end else if (i_ctl.ins) begin
            if (i_prev_bigger) begin
                r_ent <= i_prev_ent;
            end else if (o_bigger) begin
                r_ent <= i_new;
            end
        end
    end

endmodule

// ===== rtl/sorted_line_read_coalescer.sv =====
// top level: request chain, read planner and output register
// a batch loads one word per cycle; the plan state is entered the cycle after the last word
// plan: a line word per stored request before the cut (none for out-of-range lines),
// a word per read summary but the last, and a closing word: last summary or empty marker
// output words leave one per cycle while the sink is ready; no request is taken in a plan
// reset (synchronous, active low) empties the chain and loads register defaults
module sorted_line_read_coalescer #(
    parameter int MAX_REQUESTS = slrc_pkg::DEF_MAX_REQUESTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // request_line, line_begin, line_end, offset_known, zero fill
    input  logic [135:0] i_s_tdata,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // request_index, read_index, read_first_byte, rel_begin, rel_end, read_size,
    // overflow, zero fill
    output logic [207:0] o_m_tdata,
    // kind
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_PLAN = 1'b1;
    localparam int LW = slrc_pkg::LINE_W;
    localparam int BW = slrc_pkg::BYTE_W;

    logic [LW-1:0] r_total;
    logic [BW-1:0] r_max_gap;
    logic [BW-1:0] r_max_read;

    logic          r_state;
    logic [CW-1:0] r_count;
    logic          r_drop;
    logic          r_open;
    logic          r_any;
    logic [4:0]    r_ridx;
    logic [BW-1:0] r_first;
    logic [BW-1:0] r_rend;
    logic [LW-1:0] r_prev;

    logic          r_ovalid;
    logic [1:0]    r_okind;
    logic [4:0]    r_oreq;
    logic [4:0]    r_oridx;
    logic [BW-1:0] r_ofirst;
    logic [BW-1:0] r_orelb;
    logic [BW-1:0] r_orele;
    logic [BW-1:0] r_osize;
    logic          r_oovf;
    logic          r_olast;

    slrc_pkg::t_cell_ctl ctl;
    slrc_pkg::t_ent      new_ent;
    slrc_pkg::t_ent      cell_ent [MAX_REQUESTS];
    logic                cell_valid [MAX_REQUESTS];
    logic                cell_bigger [MAX_REQUESTS];

    logic          s_acc;
    logic          step;
    slrc_pkg::t_ent head;
    logic          head_v;
    logic          in_range;
    logic          finish;
    logic          joins;
    logic [BW-1:0] cur_size;
    logic          emit;
    logic          do_summary;
    logic          do_place;
    logic [BW-1:0] n_first;
    logic [BW-1:0] base_end;
    logic [BW-1:0] n_rend;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_LOAD);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign step        = (r_state == ST_PLAN) && (!r_ovalid || i_m_tready);

    assign new_ent.line  = i_s_tdata[31:0];
    assign new_ent.first = i_s_tdata[79:32];
    assign new_ent.last  = i_s_tdata[127:80];
    assign new_ent.known = i_s_tdata[128];
    assign new_ent.req   = 5'(r_count);

    assign head     = cell_ent[0];
    assign head_v   = cell_valid[0];
    assign in_range = head.line < r_total;
    assign finish   = !head_v || (in_range && !head.known);
    assign cur_size = r_rend - r_first;
    assign joins    = r_open
        && (({1'b0, head.line} <= ({1'b0, r_prev} + 33'd1))
         || (({1'b0, head.first} <= ({1'b0, r_rend} + {1'b0, r_max_gap}))
             && (cur_size < r_max_read)));
    assign do_summary = step && !finish && in_range && r_open && !joins;
    assign do_place   = step && !finish && in_range && !do_summary;
    assign emit       = (step && finish) || do_summary || do_place;
    assign n_first    = r_open ? r_first : head.first;
    assign base_end   = r_open ? r_rend : head.first;
    assign n_rend     = (head.last > base_end) ? head.last : base_end;

    assign ctl.ins = s_acc && (r_count < CW'(MAX_REQUESTS));
    assign ctl.pop = do_place || (step && !finish && !in_range);
    assign ctl.clr = step && finish;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
            slrc_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_new         (new_ent),
                .i_prev_valid  ((gi == 0) ? 1'b0 : cell_valid[(gi == 0) ? 0 : gi - 1]),
                .i_prev_ent    (cell_ent[(gi == 0) ? 0 : gi - 1]),
                .i_prev_bigger ((gi == 0) ? 1'b0 : cell_bigger[(gi == 0) ? 0 : gi - 1]),
                .i_next_valid  ((gi == MAX_REQUESTS - 1) ? 1'b0
                                : cell_valid[(gi == MAX_REQUESTS - 1) ? gi : gi + 1]),
                .i_next_ent    (cell_ent[(gi == MAX_REQUESTS - 1) ? gi : gi + 1]),
                .o_valid       (cell_valid[gi]),
                .o_ent         (cell_ent[gi]),
                .o_bigger      (cell_bigger[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= slrc_pkg::RST_TOTAL_LINES;
            r_max_gap  <= slrc_pkg::RST_MAX_GAP;
            r_max_read <= slrc_pkg::RST_MAX_READ;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                slrc_pkg::REG_TOTAL_LINES: r_total    <= i_cfg_data[LW-1:0];
                slrc_pkg::REG_MAX_GAP:     r_max_gap  <= i_cfg_data;
                slrc_pkg::REG_MAX_READ:    r_max_read <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_open   <= 1'b0;
            r_any    <= 1'b0;
            r_ridx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (s_acc) begin
                if (ctl.ins) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
                if (i_s_tlast) begin
                    r_state <= ST_PLAN;
                end
            end
            if (step && finish) begin
                r_state <= ST_LOAD;
                r_count <= '0;
                r_drop  <= 1'b0;
                r_open  <= 1'b0;
                r_any   <= 1'b0;
                r_ridx  <= '0;
            end
            if (do_summary) begin
                r_open <= 1'b0;
            end
            if (do_place) begin
                r_open <= 1'b1;
                r_any  <= 1'b1;
                if (!r_open) begin
                    r_ridx <= r_any ? r_ridx + 5'd1 : 5'd0;
                end
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_place) begin
            r_first <= n_first;
            r_rend  <= n_rend;
            r_prev  <= head.line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oovf <= r_drop;
            r_oreq <= '0;
            r_orelb <= '0;
            r_orele <= '0;
            r_osize <= '0;
            r_olast <= 1'b0;
            if (do_place) begin
                r_okind  <= slrc_pkg::KIND_LINE;
                r_oreq   <= head.req;
                r_oridx  <= r_open ? r_ridx : (r_any ? r_ridx + 5'd1 : 5'd0);
                r_ofirst <= n_first;
                r_orelb  <= head.first - n_first;
                r_orele  <= head.last - n_first;
            end else if (r_open) begin
                r_okind  <= slrc_pkg::KIND_READ;
                r_oridx  <= r_ridx;
                r_ofirst <= r_first;
                r_osize  <= cur_size;
                r_olast  <= finish;
            end else begin
                r_okind  <= slrc_pkg::KIND_EMPTY;
                r_oridx  <= '0;
                r_ofirst <= '0;
                r_olast  <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {5'd0, r_oovf, r_osize, r_orele, r_orelb, r_ofirst, r_oridx, r_oreq};

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REQUESTS))
        else $error("request count beyond capacity");
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == slrc_pkg::KIND_EMPTY) |-> o_m_tlast)
        else $error("empty plan marker without last");
    a_no_read_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_ridx == 5'd0) && !r_open)
        else $error("read open before any placement");
    a_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) && (r_count == '0) |-> !cell_valid[0])
        else $error("chain not empty at batch start");
`endif

endmodule
